// ----- rtl/dssm_pkg.sv -----
// Shared types and constants for the dual stack in one memory.
`timescale 1ns / 1ps
`default_nettype none
package dssm_pkg;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

  localparam logic SIDE_LOWER = 1'b0;
  localparam logic SIDE_UPPER = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic load;
  } ctl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/dssm_ctrl.sv -----
// Handshake controller for the dual stack: takes one transfer, then holds the result.
`timescale 1ns / 1ps
`default_nettype none
module dssm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire dssm_pkg::dp_stat_t dp_stat,
  output dssm_pkg::ctl_cmd_t     ctl_cmd
);
  import dssm_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RESP = 1'b1;

  logic state;
  logic state_next;
  logic unused_stat;

  // The datapath flags are informational here; every operation yields a result.
  assign unused_stat = dp_stat.full ^ dp_stat.empty;

  always_comb begin
    state_next   = state;
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    ctl_cmd.load = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall     = 1'b0;
        ctl_cmd.load = in_valid;
        if (in_valid) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dssm_dp.sv -----
// Datapath for the dual stack: shared memory, both fill counters and the result registers.
`timescale 1ns / 1ps
`default_nettype none
module dssm_dp #(
  parameter int DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dssm_pkg::ctl_cmd_t            ctl_cmd,
  output dssm_pkg::dp_stat_t                 dp_stat,
  input  wire logic [dssm_pkg::CMD_W-1:0]    cmd,
  input  wire logic                          side,
  input  wire logic signed [dssm_pkg::DATA_W-1:0] value,
  output logic [dssm_pkg::STATUS_W-1:0]      status,
  output logic signed [dssm_pkg::DATA_W-1:0] data,
  output logic [dssm_pkg::COUNT_W-1:0]       lower_count,
  output logic [dssm_pkg::COUNT_W-1:0]       upper_count
);
  import dssm_pkg::*;

  localparam int FW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam logic [FW:0] DEPTH_S = (FW + 1)'(DEPTH);
  localparam logic [FW-1:0] DEPTH_F = FW'(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];

  logic [FW-1:0]     lower_fill;
  logic [FW-1:0]     upper_fill;
  logic [FW-1:0]     lower_fill_next;
  logic [FW-1:0]     upper_fill_next;
  logic [DATA_W-1:0] rd_q;
  logic              use_read;
  logic [STATUS_W-1:0] status_next;
  logic              use_read_next;
  logic              full;
  logic              empty;
  logic              wr_en;
  logic              rd_en;
  logic [FW-1:0]     addr_f;
  logic [AW-1:0]     addr;

  always_comb begin
    full  = ({1'b0, lower_fill} + {1'b0, upper_fill}) >= DEPTH_S;
    empty = (side == SIDE_UPPER) ? (upper_fill == '0) : (lower_fill == '0);

    lower_fill_next = lower_fill;
    upper_fill_next = upper_fill;
    status_next     = ST_OK;
    use_read_next   = 1'b0;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    addr_f          = '0;

    priority if (cmd == CMD_PUSH) begin
      if (full) begin
        status_next = ST_FULL;
      end else if (side == SIDE_LOWER) begin
        wr_en           = 1'b1;
        addr_f          = lower_fill;
        lower_fill_next = lower_fill + 1'b1;
      end else begin
        wr_en           = 1'b1;
        addr_f          = DEPTH_F - upper_fill - 1'b1;
        upper_fill_next = upper_fill + 1'b1;
      end
    end else if (cmd == CMD_POP || cmd == CMD_PEEK) begin
      if (empty) begin
        status_next = ST_EMPTY;
      end else begin
        rd_en         = 1'b1;
        use_read_next = 1'b1;
        if (side == SIDE_LOWER) begin
          addr_f = lower_fill - 1'b1;
          if (cmd == CMD_POP) begin
            lower_fill_next = lower_fill - 1'b1;
          end
        end else begin
          addr_f = DEPTH_F - upper_fill;
          if (cmd == CMD_POP) begin
            upper_fill_next = upper_fill - 1'b1;
          end
        end
      end
    end else begin
      // Unused command code: no change, plain ok result.
      status_next = ST_OK;
    end

    addr = addr_f[AW-1:0];
  end

  assign dp_stat.full  = full;
  assign dp_stat.empty = empty;

  // Memory: one port, written on a push and read on a pop or peek.
  always_ff @(posedge clk) begin
    if (ctl_cmd.load && wr_en) begin
      mem[addr] <= value;
    end
    if (ctl_cmd.load && rd_en) begin
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_fill <= '0;
      upper_fill <= '0;
      use_read   <= 1'b0;
      status     <= ST_OK;
    end else if (ctl_cmd.load) begin
      lower_fill <= lower_fill_next;
      upper_fill <= upper_fill_next;
      use_read   <= use_read_next;
      status     <= status_next;
    end
  end

  assign data        = use_read ? $signed(rd_q) : '0;
  assign lower_count = COUNT_W'(lower_fill);
  assign upper_count = COUNT_W'(upper_fill);

endmodule
`default_nettype wire

// ----- rtl/dual_stack_shared_memory_top.sv -----
// Two stacks growing toward each other in one shared memory.
//
// Input channel: in_valid / in_stall carry cmd (push, pop, peek), side
// (lower or upper stack) and value. A transfer takes place at a rising edge
// with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry status, data and both fill
// counts; exactly one result follows each accepted operation.
// Latency: the result is valid in the cycle after the input transfer; the
// memory access (write for push, registered read for pop or peek) and the
// counter update all happen at that input edge.
// Flow: the controller holds one operation at a time, so a new operation is
// accepted only after the result of the last one has been taken.
// While out_stall is high the result holds steady and in_stall stays high.
// Reset (rst, synchronous) empties both stacks; memory contents are not
// cleared, since no entry is read before it is written.
`timescale 1ns / 1ps
`default_nettype none
module dual_stack_shared_memory_top #(
  parameter int DEPTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [dssm_pkg::CMD_W-1:0]         cmd,
  input  wire logic                               side,
  input  wire logic signed [dssm_pkg::DATA_W-1:0] value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [dssm_pkg::STATUS_W-1:0]           status,
  output logic signed [dssm_pkg::DATA_W-1:0]      data,
  output logic [dssm_pkg::COUNT_W-1:0]            lower_count,
  output logic [dssm_pkg::COUNT_W-1:0]            upper_count
);
  import dssm_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;

  dssm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_stat   (dp_stat),
    .ctl_cmd   (ctl_cmd)
  );

  dssm_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl_cmd     (ctl_cmd),
    .dp_stat     (dp_stat),
    .cmd         (cmd),
    .side        (side),
    .value       (value),
    .status      (status),
    .data        (data),
    .lower_count (lower_count),
    .upper_count (upper_count)
  );

endmodule
`default_nettype wire
